/* hdl/glyph_tile_key_cache_assert.svh */
// assertion macros for the glyph tile key cache
// no dependencies; included by gtkc_datapath, which checks its own logic
`ifndef GLYPH_TILE_KEY_CACHE_ASSERT_SVH
`define GLYPH_TILE_KEY_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// property holds in the same cycle
`define GTKC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// antecedent implies consequent in the next cycle
`define GTKC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define GTKC_ASSERT(name, clk, rst, prop)
`define GTKC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* hdl/gtkc_pkg.sv */
// shared types and constants of the glyph tile key cache
// no dependencies; imported by controller, datapath and top level
`timescale 1ns / 1ps

package gtkc_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 16;

   localparam logic [KEY_W-1:0] KEY_WIDE   = 16'hFF00;
   localparam logic [KEY_W-1:0] KEY_RAW    = 16'hFD00;
   localparam logic [KEY_W-1:0] BYTE_MASK  = 16'h00FF;
   localparam logic [7:0]       SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {
      OP_PAIR  = 2'd0,
      OP_WIDE  = 2'd1,
      OP_RAW   = 2'd2,
      OP_RESET = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] first_char;
      logic [7:0] second_char;
   } req_type;

   typedef struct packed {
      logic [7:0] tile_index;
      logic       was_cached;
      logic       needs_load;
      logic       recycled;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic take_hit;
      logic append;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic hit;
      logic exhausted;
   } status_type;

endpackage

/* hdl/gtkc_ctrl.sv */
// sequencer of the glyph tile key cache: accept, scan, result hand-off
// depends on gtkc_pkg
`timescale 1ns / 1ps

module gtkc_ctrl
   import gtkc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.start    = (state_ff == S_IDLE) && req_valid;
      cmd.scan     = (state_ff == S_SCAN);
      cmd.take_hit = (state_ff == S_SCAN) && status.hit;
      cmd.append   = (state_ff == S_SCAN) && !status.hit && status.exhausted;
      cmd.emit     = (state_ff == S_EMIT) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= status.special ? S_EMIT : S_SCAN;
               end
            end
            S_SCAN: begin
               if (status.hit || status.exhausted) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* hdl/gtkc_datapath.sv */
// key store, fill count, scan pointer and result registers of the cache
// depends on gtkc_pkg and glyph_tile_key_cache_assert.svh
`timescale 1ns / 1ps
`include "glyph_tile_key_cache_assert.svh"

module gtkc_datapath
   import gtkc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_write,
   input  logic [7:0] csr_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   logic [KEY_W-1:0] key_store [ENTRIES];

   logic [7:0]       base_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] scan_ff;
   logic             rd_pending_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] cmp_slot_ff;
   logic [KEY_W-1:0] key_ff;
   rsp_type          res_ff;
   rsp_type          rsp_ff;

   logic [KEY_W-1:0] key_in;
   logic             blank;
   logic             issue;
   logic             full;
   logic [IDX_W-1:0] alloc_slot;

   // key formed from the incoming item
   always_comb begin
      case (req_data.opcode)
         OP_PAIR: key_in = {req_data.first_char, req_data.second_char};
         OP_WIDE: key_in = KEY_WIDE | {8'h00, req_data.first_char};
         OP_RAW:  key_in = KEY_RAW | (KEY_W'(fill_ff) & BYTE_MASK);
         default: key_in = '0;
      endcase
   end

   assign blank = (req_data.opcode == OP_PAIR) &&
                  (req_data.first_char == SPACE_CHAR) &&
                  (req_data.second_char == SPACE_CHAR);

   assign issue      = cmd.scan && (scan_ff < fill_ff);
   assign full       = (fill_ff >= CNT_W'(ENTRIES));
   assign alloc_slot = full ? '0 : fill_ff[IDX_W-1:0];

   assign status.special   = blank || (req_data.opcode == OP_RESET);
   assign status.hit       = rd_pending_ff && (rd_data_ff == key_ff);
   assign status.exhausted = !rd_pending_ff && (scan_ff >= fill_ff);

   assign rsp_data = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         fill_ff       <= '0;
         scan_ff       <= '0;
         rd_pending_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            base_ff <= csr_data;
         end
         if (cmd.start) begin
            scan_ff       <= '0;
            rd_pending_ff <= 1'b0;
            if (req_data.opcode == OP_RESET) begin
               fill_ff <= '0;
            end
         end else begin
            rd_pending_ff <= issue;
            if (issue) begin
               scan_ff <= scan_ff + CNT_W'(1);
            end
            if (cmd.append) begin
               fill_ff <= CNT_W'(alloc_slot) + CNT_W'(1);
            end
         end
      end
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff  <= key_store[scan_ff[IDX_W-1:0]];
         cmp_slot_ff <= scan_ff[IDX_W-1:0];
      end
      if (cmd.append) begin
         key_store[alloc_slot] <= key_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff            <= key_in;
         res_ff.tile_index <= '0;
         res_ff.was_cached <= blank;
         res_ff.needs_load <= 1'b0;
         res_ff.recycled   <= 1'b0;
      end else if (cmd.take_hit) begin
         res_ff.tile_index <= base_ff + 8'(cmp_slot_ff);
         res_ff.was_cached <= 1'b1;
         res_ff.needs_load <= 1'b0;
         res_ff.recycled   <= 1'b0;
      end else if (cmd.append) begin
         res_ff.tile_index <= base_ff + 8'(alloc_slot);
         res_ff.was_cached <= 1'b0;
         res_ff.needs_load <= 1'b1;
         res_ff.recycled   <= full;
      end
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
   end

   `GTKC_ASSERT(fill_in_range_a, clock, reset, fill_ff <= CNT_W'(ENTRIES))
   `GTKC_ASSERT_NEXT(append_fills_a, clock, reset, cmd.append, fill_ff != '0)
   `GTKC_ASSERT_NEXT(read_below_fill_a, clock, reset, issue && !cmd.start,
      rd_pending_ff && (CNT_W'(cmp_slot_ff) < fill_ff))

endmodule

/* hdl/glyph_tile_key_cache.sv */
// top level of the glyph tile key cache
// depends on gtkc_pkg, gtkc_ctrl and gtkc_datapath
//
//   channel  | ports                          | direction | content
//   request  | req_valid, req_stall, req_data | in        | opcode, first_char, second_char
//   response | rsp_valid, rsp_stall, rsp_data | out       | tile_index and three flags
//   csr      | csr_write, csr_data            | in        | base_tile, no read-back
//
// a blank pair or a pool reset skips the key store scan and goes straight to the result
// a lookup walks the key store one entry a cycle through its single read port:
//   a hit stops the walk at its slot, a miss walks every filled entry
// one item is in work at a time; a new transfer is taken once the previous
//   result sits in the output register, even while that result is stalled
// synchronous reset empties the pool and clears base_tile; the key store is not cleared
`timescale 1ns / 1ps

module glyph_tile_key_cache
   import gtkc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   // configuration
   input  logic       csr_write,
   input  logic [7:0] csr_data
);

   // command and status between the sequencer and the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: owns the handshakes and the scan/append/emit ordering
   gtkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: key memory, fill count, compare and result registers
   gtkc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
